### rtl/core/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro names its assertion, samples on clk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies consequence in the same cycle.
`define KMS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kms assertion failed");

// Condition implies consequence in the next cycle.
`define KMS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kms assertion failed");

`endif

### rtl/core/kms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_pkg
// Shared types and constants of the key membership set.
// ----------------------------------------------------------------------------
package kms_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_W        = 64;

	// Request kinds; the fourth code is a no-op.
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_ERASE  = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CLAIM,
		ST_HOLD
	} kms_state_t;

	// Token that walks the cell chain, one cell per cycle.
	// In a claim pass, hit marks that a slot has already been taken.
	typedef struct packed {
		logic              active;
		logic              claim;
		logic [1:0]        op;
		logic [KEY_W-1:0]  key;
		logic              hit;
		logic              free_seen;
	} kms_token_t;

endpackage

### rtl/core/kms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_cell
// One slot of the set: holds a key and its valid bit, and registers the
// passing token on to the next cell.
// ----------------------------------------------------------------------------
module kms_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  kms_pkg::kms_token_t tok_in,
	output kms_pkg::kms_token_t tok_out
);

	logic [kms_pkg::KEY_W-1:0] key_q;
	logic                      valid_q;
	kms_pkg::kms_token_t       tok_s1;
	kms_pkg::kms_token_t       tok_nxt;
	logic                      match;
	logic                      take;
	logic                      drop;

	always_comb begin
		match = valid_q && (key_q == tok_in.key);
		take  = tok_in.active && tok_in.claim && !tok_in.hit && !valid_q;
		drop  = tok_in.active && !tok_in.claim && match && (tok_in.op == kms_pkg::REQ_ERASE);
		tok_nxt = tok_in;
		if (tok_in.claim) begin
			tok_nxt.hit = tok_in.hit | take;
		end else begin
			tok_nxt.hit       = tok_in.hit | match;
			tok_nxt.free_seen = tok_in.free_seen | !valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_s1  <= '0;
		end else begin
			if (take) begin
				valid_q <= 1'b1;
			end else if (drop) begin
				valid_q <= 1'b0;
			end
			tok_s1 <= tok_nxt;
		end
	end

	// key store: no reset
	always_ff @(posedge clk) begin
		if (take) begin
			key_q <= tok_in.key;
		end
	end

	assign tok_out = tok_s1;

endmodule

### rtl/core/kms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_ctrl
// Request sequencer: launches search and claim passes into the chain,
// decodes the returning token and drives the output register.
// ----------------------------------------------------------------------------
module kms_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [1:0]                req_type,
	input  logic [kms_pkg::KEY_W-1:0] req_key,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      present,
	output logic                      full_error,
	output kms_pkg::kms_token_t       head_tok,
	input  kms_pkg::kms_token_t       tail_tok
);

	kms_pkg::kms_state_t state_q, state_nxt;
	logic out_valid_q;
	logic present_q, full_error_q;
	logic res_present_q, res_full_q;
	logic fin, fin_present, fin_full;
	logic load, load_present, load_full;
	logic hold_save;
	logic new_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kms_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			present_q    <= load_present;
			full_error_q <= load_full;
		end
		if (hold_save) begin
			res_present_q <= fin_present;
			res_full_q    <= fin_full;
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		head_tok     = '0;
		fin          = 1'b0;
		fin_present  = 1'b0;
		fin_full     = 1'b0;
		load         = 1'b0;
		load_present = 1'b0;
		load_full    = 1'b0;
		hold_save    = 1'b0;
		new_key      = (tail_tok.op == kms_pkg::REQ_INSERT) && !tail_tok.hit;
		case (state_q)
			kms_pkg::ST_IDLE: begin
				in_ready        = 1'b1;
				head_tok.active = in_valid;
				head_tok.op     = req_type;
				head_tok.key    = req_key;
				if (in_valid) begin
					state_nxt = kms_pkg::ST_SEARCH;
				end
			end
			kms_pkg::ST_SEARCH: begin
				if (tail_tok.active) begin
					if (new_key && tail_tok.free_seen) begin
						head_tok.active = 1'b1;
						head_tok.claim  = 1'b1;
						head_tok.op     = tail_tok.op;
						head_tok.key    = tail_tok.key;
						state_nxt       = kms_pkg::ST_CLAIM;
					end else begin
						fin         = 1'b1;
						fin_present = (tail_tok.op == kms_pkg::REQ_QUERY) && tail_tok.hit;
						fin_full    = new_key && !tail_tok.free_seen;
					end
				end
			end
			kms_pkg::ST_CLAIM: begin
				if (tail_tok.active) begin
					fin = 1'b1;
				end
			end
			kms_pkg::ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load         = 1'b1;
					load_present = res_present_q;
					load_full    = res_full_q;
					state_nxt    = kms_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = kms_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			if (!out_valid_q || out_ready) begin
				load         = 1'b1;
				load_present = fin_present;
				load_full    = fin_full;
				state_nxt    = kms_pkg::ST_IDLE;
			end else begin
				hold_save = 1'b1;
				state_nxt = kms_pkg::ST_HOLD;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign present    = present_q;
	assign full_error = full_error_q;

endmodule

### rtl/core/key_membership_set_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_membership_set_core
// Bounded set of 64-bit keys with insert, erase and query, built as a chain
// of slot cells that a request token walks through.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------
//  request | in_valid / in_ready   | req_type[1:0], key[63:0]
//  result  | out_valid / out_ready | present, full_error
//
// A request token enters cell 0 on the transfer and moves one cell per
// cycle. Query, erase, a duplicate insert and a refused insert finish after
// one pass: the result register loads as the token leaves the last cell
// unless the output is stalled, and in_ready returns the cycle after, so
// one request is handled at a time. An insert of a new key into a table
// with room makes a second, claiming pass that writes the lowest free
// slot. Each pass walks the whole chain of CAPACITY cells.
// Reset clears all valid bits and the sequencer; stored keys are not reset.
// A stalled result waits in the output register; a finished item behind it
// waits in the sequencer, and no new request is taken until it moves on.
// ----------------------------------------------------------------------------
module key_membership_set_core #(
	parameter int CAPACITY = kms_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic signed [kms_pkg::KEY_W-1:0] key,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             present,
	output logic                             full_error
);

	// token links: chain[i] feeds cell i, chain[CAPACITY] is the tail
	kms_pkg::kms_token_t chain [CAPACITY+1];

	kms_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.req_key    ($unsigned(key)),  // compared as a raw bit pattern
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.present    (present),
		.full_error (full_error),
		.head_tok   (chain[0]),
		.tail_tok   (chain[CAPACITY])
	);

	// Cell 0 is the lowest slot, so a claim pass fills the lowest free one.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kms_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (chain[i]),
			.tok_out (chain[i+1])
		);
	end

endmodule

### rtl/core/kms_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kms_checker
// Port-level checks on the key membership set.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kms_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic present,
	input logic full_error
);

	// a pending result is not withdrawn
	`KMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// and its flags stay put
	`KMS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(present) && $stable(full_error))
	// only a query reports presence, only an insert reports a full table
	`KMS_ASSERT_SAME(a_flags_excl, out_valid, !(present && full_error))
	// one request in flight: busy right after a transfer
	`KMS_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready)

endmodule

bind key_membership_set_core kms_checker u_kms_checker (.*);
